// File: rtl/lpdc_pkg.sv
package lpdc_pkg;

    localparam int ATAN_ENTRIES = 24;
    localparam logic signed [33:0] PI_Q29 = 34'sd1686629713;
    localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;

    typedef enum logic [1:0] {
        KIND_POINT    = 2'd0,
        KIND_EOC_LAST = 2'd1,
        KIND_EOC_MORE = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        RT_STRONGEST = 3'd0,
        RT_FIRST     = 3'd1,
        RT_LAST      = 3'd2,
        RT_SECOND    = 3'd3,
        RT_UNKNOWN   = 3'd4
    } rtype_t;

    localparam logic [1:0] MODE_FIRST  = 2'd0;
    localparam logic [1:0] MODE_LAST   = 2'd1;
    localparam logic [1:0] MODE_SECOND = 2'd2;

    localparam logic CMD_HEADER = 1'b0;

    function automatic logic signed [33:0] atan_q30(input int i);
        logic signed [33:0] t [ATAN_ENTRIES];
        t = '{34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159,
              34'sd67021687, 34'sd33543516, 34'sd16775851, 34'sd8388437,
              34'sd4194283, 34'sd2097149, 34'sd1048576, 34'sd524288,
              34'sd262144, 34'sd131072, 34'sd65536, 34'sd32768,
              34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
              34'sd1024, 34'sd512, 34'sd256, 34'sd128};
        return t[i];
    endfunction

    // Sideband carried down the CORDIC row with each point
    typedef struct packed {
        logic        eoc;
        logic        pt;
        logic [63:0] eoc_time;
        logic [19:0] rng;
        logic [15:0] az_rad;
        logic [15:0] el_rad;
        rtype_t      rtype;
        logic [15:0] vel;
        logic [7:0]  inten;
        logic [63:0] rel_time;
        logic [15:0] chan;
    } side_t;

endpackage

// File: rtl/lpdc_if.sv
interface lpdc_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic signed [16:0] sync_point;
    logic [31:0] tick_ns;
    logic [15:0] start_line;
    logic [63:0] first_timestamp_ns;
    logic [7:0]  peak_id;
    logic [2:0]  point_flags;
    logic [19:0] range;
    logic signed [15:0] azimuth;
    logic signed [15:0] elevation;
    logic signed [15:0] velocity;
    logic [7:0]  intensity;
    modport source (output valid, command, sync_point, tick_ns, start_line,
        first_timestamp_ns, peak_id, point_flags, range, azimuth, elevation, velocity,
        intensity, input ready);
    modport sink (input valid, command, sync_point, tick_ns, start_line,
        first_timestamp_ns, peak_id, point_flags, range, azimuth, elevation, velocity,
        intensity, output ready);
endinterface

interface lpdc_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic signed [20:0] x;
    logic signed [20:0] y;
    logic signed [20:0] z;
    logic [19:0] distance;
    logic signed [15:0] azimuth_rad;
    logic signed [15:0] elevation_rad;
    logic [2:0]  echo_kind;
    logic signed [15:0] radial_vel;
    logic [7:0]  point_intensity;
    logic [63:0] time_ns;
    logic [15:0] channel;
    modport source (output valid, kind, x, y, z, distance, azimuth_rad, elevation_rad,
        echo_kind, radial_vel, point_intensity, time_ns, channel, input ready);
    modport sink (input valid, kind, x, y, z, distance, azimuth_rad, elevation_rad,
        echo_kind, radial_vel, point_intensity, time_ns, channel, output ready);
endinterface

interface lpdc_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

// File: rtl/lidar_point_decode_cartesian.sv
// Path: CORDIC row, then product registers, then the output register.
// Throughput: one item per cycle when not stalled, set by the pipelined CORDIC row;
// and an item with an end-of-cloud and a point stalls input until the point is sent.
// Reset: rst_n asynchronous active low; clears time, counters, boundary (none),
// return mode and pipeline valid bits.
module lidar_point_decode_cartesian
    import lpdc_pkg::*;
#(
    parameter int INDEX_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input logic     clk,
    input logic     rst_n,
    lpdc_in_if.sink   in_ch,
    lpdc_out_if.source out_ch,
    lpdc_cfg_if.sink  cfg
);

    localparam int NS = CORDIC_STAGES;
    localparam int D  = NS + 2;

    logic [1:0] mode_reg;
    logic       adv;
    logic       take;
    side_t      side_in;
    logic signed [33:0] az0, el0;
    logic [19:0] rng0;

    logic  [D-1:0] v_reg;
    side_t sd_reg [D];
    logic [19:0] d_reg [NS];

    logic signed [33:0] ax [NS+1];
    logic signed [33:0] ay [NS+1];
    logic signed [33:0] az [NS+1];
    logic signed [33:0] ex [NS+1];
    logic signed [33:0] ey [NS+1];
    logic signed [33:0] ez [NS+1];

    logic signed [31:0] xy_reg;
    logic signed [53:0] zp_reg;
    logic signed [31:0] saz_reg, caz_reg;
    logic signed [63:0] xp_reg, yp_reg;
    logic signed [53:0] zq_reg;

    logic       ov_reg;
    logic       pend_reg;
    side_t      os_reg;
    logic signed [20:0] ox_reg, oy_reg, oz_reg;

    assign cfg.ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= '0;
        else if (cfg.valid)
            mode_reg <= cfg.data;
    end

    assign adv = !ov_reg || (out_ch.ready && !pend_reg);
    assign in_ch.ready = adv;
    assign take = in_ch.valid && adv;

    lpdc_front #(.INDEX_BITS(INDEX_BITS)) u_front (
        .clk(clk), .rst_n(rst_n), .take(take), .mode(mode_reg), .in_ch(in_ch),
        .side(side_in), .az(az0), .el(el0), .rng(rng0)
    );

    assign ax[0] = CORDIC_GAIN_Q30;
    assign ay[0] = '0;
    assign az[0] = az0;
    assign ex[0] = CORDIC_GAIN_Q30;
    assign ey[0] = '0;
    assign ez[0] = el0;

    for (genvar i = 0; i < NS; i++)
    begin : g_row
        lpdc_cordic_cell #(.STAGE(i)) u_a (
            .clk(clk), .adv(adv), .x_in(ax[i]), .y_in(ay[i]), .z_in(az[i]),
            .x_reg(ax[i+1]), .y_reg(ay[i+1]), .z_reg(az[i+1])
        );
        lpdc_cordic_cell #(.STAGE(i)) u_e (
            .clk(clk), .adv(adv), .x_in(ex[i]), .y_in(ey[i]), .z_in(ez[i]),
            .x_reg(ex[i+1]), .y_reg(ey[i+1]), .z_reg(ez[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (adv)
            v_reg <= {v_reg[D-2:0], take && (side_in.eoc || side_in.pt)};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sd_reg[0] <= side_in;
            for (int k = 1; k < D; k++)
                sd_reg[k] <= sd_reg[k-1];
            d_reg[0] <= rng0;
            for (int k = 1; k < NS; k++)
                d_reg[k] <= d_reg[k-1];
            xy_reg  <= 32'((54'(signed'({1'b0, d_reg[NS-1]})) * 54'(ex[NS])
                        + 54'sd524288) >>> 20);
            zp_reg  <= 54'(signed'({1'b0, d_reg[NS-1]})) * 54'(ey[NS]);
            saz_reg <= 32'(ay[NS]);
            caz_reg <= 32'(ax[NS]);
            xp_reg  <= 64'(xy_reg) * 64'(saz_reg);
            yp_reg  <= 64'(xy_reg) * 64'(caz_reg);
            zq_reg  <= zp_reg;
        end
    end

    function automatic logic signed [20:0] sat21(input logic signed [63:0] v);
        if (v > 64'sd1048575)
            return 21'sd1048575;
        if (v < -64'sd1048576)
            return -21'sd1048576;
        return v[20:0];
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg   <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (pend_reg && out_ch.ready)
            pend_reg <= 1'b0;
        else if (adv)
        begin
            ov_reg   <= v_reg[D-1];
            pend_reg <= v_reg[D-1] && sd_reg[D-1].eoc && sd_reg[D-1].pt;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            os_reg <= sd_reg[D-1];
            ox_reg <= sat21((xp_reg + (64'sd1 <<< 39)) >>> 40);
            oy_reg <= sat21((yp_reg + (64'sd1 <<< 39)) >>> 40);
            oz_reg <= sat21(64'((54'(zq_reg) + (54'sd1 <<< 29)) >>> 30));
        end
    end

    logic show_eoc;
    assign show_eoc = os_reg.eoc && (pend_reg || !os_reg.pt);

    always_comb
    begin
        out_ch.valid = ov_reg;
        if (show_eoc)
        begin
            out_ch.kind = pend_reg ? KIND_EOC_MORE : KIND_EOC_LAST;
            out_ch.x = '0; out_ch.y = '0; out_ch.z = '0;
            out_ch.distance = '0; out_ch.azimuth_rad = '0; out_ch.elevation_rad = '0;
            out_ch.echo_kind = '0; out_ch.radial_vel = '0;
            out_ch.point_intensity = '0; out_ch.time_ns = os_reg.eoc_time;
            out_ch.channel = '0;
        end
        else
        begin
            out_ch.kind = KIND_POINT;
            out_ch.x = ox_reg; out_ch.y = oy_reg; out_ch.z = oz_reg;
            out_ch.distance = os_reg.rng;
            out_ch.azimuth_rad = os_reg.az_rad;
            out_ch.elevation_rad = os_reg.el_rad;
            out_ch.echo_kind = os_reg.rtype;
            out_ch.radial_vel = os_reg.vel;
            out_ch.point_intensity = os_reg.inten;
            out_ch.time_ns = os_reg.rel_time;
            out_ch.channel = os_reg.chan;
        end
    end

`ifndef SYNTHESIS
    a_pend_valid: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> ov_reg) else $error("pending point without output");
    a_no_take_pend: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !in_ch.ready) else $error("input taken while split pending");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ch.ready) |=> ov_reg) else $error("result dropped");
`endif

endmodule

// File: rtl/lpdc_cordic_cell.sv
module lpdc_cordic_cell
    import lpdc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic               clk,
    input  logic               adv,
    input  logic signed [33:0] x_in,
    input  logic signed [33:0] y_in,
    input  logic signed [33:0] z_in,
    output logic signed [33:0] x_reg,
    output logic signed [33:0] y_reg,
    output logic signed [33:0] z_reg
);

    logic signed [33:0] dx;
    logic signed [33:0] dy;

    assign dx = y_in >>> STAGE;
    assign dy = x_in >>> STAGE;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (!z_in[33])
            begin
                x_reg <= x_in - dx;
                y_reg <= y_in + dy;
                z_reg <= z_in - atan_q30(STAGE);
            end
            else
            begin
                x_reg <= x_in + dx;
                y_reg <= y_in - dy;
                z_reg <= z_in + atan_q30(STAGE);
            end
        end
    end

endmodule

// File: rtl/lpdc_front.sv
module lpdc_front
    import lpdc_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [1:0]         mode,
    lpdc_in_if.sink            in_ch,
    output side_t              side,
    output logic signed [33:0] az,
    output logic signed [33:0] el,
    output logic [19:0]        rng
);

    logic [63:0]         abs_reg;
    logic [31:0]         step_reg;
    logic [15:0]         line_reg;
    logic [INDEX_BITS:0] cnt_reg;
    logic [INDEX_BITS:0] bnd_reg;
    logic                bnd_ok_reg;
    logic [63:0]         cst_reg;
    logic                has_reg;

    logic [63:0] abs_now;
    logic [63:0] cst_now;
    logic        hit;
    logic        vld;
    logic [15:0] line_now;
    logic signed [51:0] az_p;
    logic signed [51:0] el_p;
    logic signed [33:0] az_a;
    logic signed [33:0] el_a;
    logic signed [17:0] az_r;
    logic signed [17:0] el_r;
    logic [INDEX_BITS:0] cnt_next;
    logic signed [16:0] fsi;
    rtype_t rt;

    assign fsi = in_ch.sync_point;
    assign abs_now = abs_reg + ((in_ch.point_flags[2] && in_ch.peak_id == 8'd0)
                     ? {32'd0, step_reg} : 64'd0);
    assign hit = bnd_ok_reg && (cnt_reg == bnd_reg);
    assign vld = in_ch.point_flags[0];
    assign line_now = line_reg + {15'd0, in_ch.point_flags[1]};
    assign cst_now = (!has_reg || hit) ? abs_now : cst_reg;
    assign cnt_next = cnt_reg[INDEX_BITS] ? cnt_reg : cnt_reg + 1'b1;

    assign az_p = -(52'(in_ch.azimuth) * 52'(PI_Q29)) + 52'sd16384;
    assign el_p = 52'(in_ch.elevation) * 52'(PI_Q29) + 52'sd32768;
    assign az_a = 34'(az_p >>> 15);
    assign el_a = 34'(el_p >>> 16);
    assign az_r = 18'((az_a + 34'sd32768) >>> 16);
    assign el_r = 18'((el_a + 34'sd32768) >>> 16);

    always_comb
    begin
        priority if (in_ch.peak_id == 8'd0)
            rt = RT_STRONGEST;
        else if (in_ch.peak_id > 8'd1)
            rt = RT_UNKNOWN;
        else if (mode == MODE_FIRST)
            rt = RT_FIRST;
        else if (mode == MODE_LAST)
            rt = RT_LAST;
        else if (mode == MODE_SECOND)
            rt = RT_SECOND;
        else
            rt = RT_UNKNOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_reg    <= '0;
            step_reg   <= '0;
            line_reg   <= '0;
            cnt_reg    <= '0;
            bnd_reg    <= '0;
            bnd_ok_reg <= 1'b0;
            cst_reg    <= '0;
            has_reg    <= 1'b0;
        end
        else if (take)
        begin
            if (in_ch.command == CMD_HEADER)
            begin
                abs_reg    <= in_ch.first_timestamp_ns;
                step_reg   <= in_ch.tick_ns;
                line_reg   <= in_ch.start_line;
                cnt_reg    <= '0;
                bnd_reg    <= (INDEX_BITS + 1)'(unsigned'(fsi[15:0]));
                bnd_ok_reg <= !fsi[16] && ((32'(unsigned'(fsi[15:0])) >> INDEX_BITS) == 0);
            end
            else
            begin
                abs_reg  <= abs_now;
                line_reg <= line_now;
                cnt_reg  <= cnt_next;
                if (vld)
                begin
                    cst_reg <= cst_now;
                    has_reg <= 1'b1;
                end
                else if (hit)
                begin
                    cst_reg <= '0;
                    has_reg <= 1'b0;
                end
            end
        end
    end

    always_comb
    begin
        side.eoc      = (in_ch.command != CMD_HEADER) && hit;
        side.pt       = (in_ch.command != CMD_HEADER) && vld;
        side.eoc_time = hit ? cst_reg : 64'd0;
        side.rng      = in_ch.range;
        side.az_rad   = az_r[15:0];
        side.el_rad   = el_r[15:0];
        side.rtype    = rt;
        side.vel      = in_ch.velocity;
        side.inten    = in_ch.intensity;
        side.rel_time = abs_now - cst_now;
        side.chan     = line_now;
    end

    assign az  = az_a;
    assign el  = el_a;
    assign rng = in_ch.range;

endmodule

// File: bench/lidar_point_decode_cartesian_test.sv
module lidar_point_decode_cartesian_test;
    import lpdc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_RANDOM = 1550;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 40;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic CMD_POINT = 1'b1;
    localparam logic [1:0] MODE_OTHER = 2'd3;
    localparam logic [2:0] FLAG_VALID = 3'b001;
    localparam logic [2:0] FLAG_LINE = 3'b010;
    localparam logic [2:0] FLAG_BEAM0 = 3'b100;
    localparam longint GAIN = 652032874;
    localparam longint PI_Q29_VAL = 1686629713;

    typedef struct packed {
        logic               command;
        logic signed [16:0] sync_point;
        logic [31:0]        tick_ns;
        logic [15:0]        start_line;
        logic [63:0]        first_timestamp_ns;
        logic [7:0]         peak_id;
        logic [2:0]         point_flags;
        logic [19:0]        range;
        logic signed [15:0] azimuth;
        logic signed [15:0] elevation;
        logic signed [15:0] velocity;
        logic [7:0]         intensity;
    } lidar_item_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [20:0] x;
        logic signed [20:0] y;
        logic signed [20:0] z;
        logic [19:0]        distance;
        logic signed [15:0] azimuth_rad;
        logic signed [15:0] elevation_rad;
        logic [2:0]         echo_kind;
        logic signed [15:0] radial_vel;
        logic [7:0]         point_intensity;
        logic [63:0]        time_ns;
        logic [15:0]        channel;
    } cart_point_t;

    logic clk;
    logic rst_n;

    lpdc_in_if  in_ch();
    lpdc_out_if out_ch();
    lpdc_cfg_if cfg();

    lidar_point_decode_cartesian DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source),
        .cfg    (cfg.sink)
    );

    lidar_item_t pending_items[$];
    cart_point_t expected_points[$];

    logic [63:0] abs_time = '0;
    logic [31:0] step_ns = '0;
    logic [15:0] line_idx = '0;
    int          pt_count = 0;
    int          sync_index = -1;
    logic [63:0] cloud_t0 = '0;
    bit          cloud_open = 0;
    logic [1:0]  mode;

    bit          stimulus_done;
    bit          failed;
    bit          no_idle;
    bit          hold_off_req;
    bit          hold_off_done;
    int          hold_off_left;
    int          idle_cycles;
    int          sent_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    // 128-bit round half up, for products that may exceed 64 bits
    function automatic longint round_shift_wide(logic signed [127:0] v, int s);
        logic signed [127:0] r;
        r = (v + (128'sd1 <<< (s - 1))) >>> s;
        return longint'(r);
    endfunction

    function automatic logic signed [20:0] clamp21(longint v);
        if (v > 1048575)
            return 21'sd1048575;
        if (v < -1048576)
            return -21'sd1048576;
        return v[20:0];
    endfunction

    task automatic rotate(input longint angle, output longint c, output longint s);
        longint xr, yr, zr, dx, dy;
        xr = GAIN;
        yr = 0;
        zr = angle;
        for (int i = 0; i < 16; i++)
        begin
            dx = floor_shift(yr, i);
            dy = floor_shift(xr, i);
            if (zr >= 0)
            begin
                xr -= dx;
                yr += dy;
                zr -= longint'(atan_q30(i));
            end
            else
            begin
                xr += dx;
                yr -= dy;
                zr += longint'(atan_q30(i));
            end
        end
        c = xr;
        s = yr;
    endtask

    function automatic rtype_t peak_return_type(logic [7:0] peak);
        if (peak == 0)
            return RT_STRONGEST;
        if (peak > 1)
            return RT_UNKNOWN;
        case (mode)
            MODE_FIRST:  return RT_FIRST;
            MODE_LAST:   return RT_LAST;
            MODE_SECOND: return RT_SECOND;
            default:     return RT_UNKNOWN;
        endcase
    endfunction

    task automatic decode_point(input lidar_item_t it);
        cart_point_t eoc, pt;
        bit          have_eoc;
        longint      d, a, e, az, el, caz, saz, cel, sel, xy;
        have_eoc = 0;
        if (it.command == CMD_HEADER)
        begin
            abs_time = it.first_timestamp_ns;
            step_ns = it.tick_ns;
            line_idx = it.start_line;
            pt_count = 0;
            sync_index = (it.sync_point >= 0) ? int'(it.sync_point) : -1;
            return;
        end
        if (it.point_flags[2] && it.peak_id == 0)
            abs_time += 64'(step_ns);
        if (sync_index >= 0 && pt_count == sync_index)
        begin
            eoc = '0;
            eoc.kind = KIND_EOC_LAST;
            eoc.time_ns = cloud_t0;
            cloud_t0 = '0;
            cloud_open = 0;
            have_eoc = 1;
        end
        if (it.point_flags[1])
            line_idx++;
        if (pt_count < 65536)
            pt_count++;
        if (it.point_flags[0])
        begin
            d = longint'(it.range);
            a = longint'(it.azimuth);
            e = longint'(it.elevation);
            az = round_shift(-a * PI_Q29_VAL, 15);
            el = round_shift(e * PI_Q29_VAL, 16);
            if (!cloud_open)
            begin
                cloud_t0 = abs_time;
                cloud_open = 1;
            end
            rotate(az, caz, saz);
            rotate(el, cel, sel);
            xy = round_shift(d * cel, 20);
            if (have_eoc)
                eoc.kind = KIND_EOC_MORE;
            pt.kind = KIND_POINT;
            pt.x = clamp21(round_shift_wide(128'(signed'(xy)) * 128'(signed'(saz)), 40));
            pt.y = clamp21(round_shift_wide(128'(signed'(xy)) * 128'(signed'(caz)), 40));
            pt.z = clamp21(round_shift(d * sel, 30));
            pt.distance = it.range;
            pt.azimuth_rad = 16'(round_shift(az, 16));
            pt.elevation_rad = 16'(round_shift(el, 16));
            pt.echo_kind = peak_return_type(it.peak_id);
            pt.radial_vel = it.velocity;
            pt.point_intensity = it.intensity;
            pt.time_ns = abs_time - cloud_t0;
            pt.channel = line_idx;
        end
        if (have_eoc)
            expected_points.push_back(eoc);
        if (it.point_flags[0])
            expected_points.push_back(pt);
    endtask

    function automatic lidar_item_t make_header(int sync, logic [31:0] step,
                                                logic [15:0] line, logic [63:0] t0);
        lidar_item_t it;
        it = lidar_item_t'($urandom());
        it.command = CMD_HEADER;
        it.sync_point = 17'(sync);
        it.tick_ns = step;
        it.start_line = line;
        it.first_timestamp_ns = t0;
        return it;
    endfunction

    function automatic lidar_item_t make_point(logic [7:0] peak, logic [2:0] flags,
                                               logic [19:0] rng, logic [15:0] az,
                                               logic [15:0] el);
        lidar_item_t it;
        it.command = CMD_POINT;
        it.sync_point = 17'($urandom());
        it.tick_ns = $urandom();
        it.start_line = 16'($urandom());
        it.first_timestamp_ns = {$urandom(), $urandom()};
        it.peak_id = peak;
        it.point_flags = flags;
        it.range = rng;
        it.azimuth = az;
        it.elevation = el;
        it.velocity = 16'($urandom());
        it.intensity = 8'($urandom());
        return it;
    endfunction

    function automatic lidar_item_t random_point();
        logic [7:0]  peak;
        logic [19:0] rng;
        case ($urandom_range(0, 9))
            0:       peak = 8'($urandom());
            1, 2, 3: peak = 8'd1;
            default: peak = 8'd0;
        endcase
        rng = ($urandom_range(0, 3) == 0) ? 20'($urandom()) : 20'($urandom_range(0, 4095));
        return make_point(peak, 3'($urandom()), rng, 16'($urandom()), 16'($urandom()));
    endfunction

    function automatic lidar_item_t random_header();
        int sync;
        case ($urandom_range(0, 9))
            0:       sync = -1;
            1:       sync = int'(17'($urandom())) - 65536;
            2:       sync = 65535;
            default: sync = $urandom_range(0, 40);
        endcase
        return make_header(sync, ($urandom_range(0, 3) == 0) ? $urandom() :
                           32'($urandom_range(0, 1000)), 16'($urandom()),
                           {$urandom(), $urandom()});
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || expected_points.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_mode(input logic [1:0] m);
        @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.data <= m;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        mode = m;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        mode = MODE_FIRST;
        stimulus_done = 0;
        no_idle = 0;
        hold_off_req = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        pending_items.push_back(make_point(8'd0, FLAG_VALID, 20'd256, 16'd0, 16'd0));
        pending_items.push_back(make_header(2, 32'd100, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FF00));
        pending_items.push_back(make_point(8'd0, FLAG_BEAM0, 20'd0, 16'd0, 16'd0));
        pending_items.push_back(make_point(8'd1, FLAG_VALID | FLAG_LINE, 20'hFFFFF,
                                           16'h8000, 16'h8000));
        pending_items.push_back(make_point(8'd0, 3'b111, 20'hFFFFF, 16'h7FFF, 16'h7FFF));
        pending_items.push_back(make_point(8'd255, FLAG_VALID | FLAG_BEAM0, 20'd1000,
                                           16'h4000, 16'hC000));
        pending_items.push_back(make_point(8'd2, FLAG_VALID, 20'd5000, 16'hC000, 16'h4000));
        pending_items.push_back(make_header(-1, 32'hFFFF_FFFF, 16'd0, 64'd0));
        pending_items.push_back(make_point(8'd0, 3'b101, 20'd77, 16'h2000, 16'h0001));
        pending_items.push_back(make_header(-65536, 32'd1, 16'd5, 64'd10));
        pending_items.push_back(make_point(8'd0, FLAG_VALID, 20'd12, 16'hFFFF, 16'hFFFF));
        pending_items.push_back(make_header(0, 32'd7, 16'd9, 64'd1000));
        pending_items.push_back(make_point(8'd1, FLAG_BEAM0, 20'd3, 16'd1, 16'd1));
        pending_items.push_back(make_point(8'd1, 3'b111, 20'd300, 16'h1234, 16'h4321));
        wait_drained();

        for (int phase = 0; phase < 5; phase++)
        begin
            set_mode(phase == 0 ? MODE_LAST : phase == 1 ? MODE_SECOND :
                     phase == 2 ? MODE_OTHER : MODE_FIRST);
            no_idle = (phase == 2);
            if (phase == 1)
                hold_off_req = 1;
            for (int n = 0; n < NUM_RANDOM / 5; n++)
            begin
                if ($urandom_range(0, 29) == 0)
                    pending_items.push_back(random_header());
                else
                    pending_items.push_back(random_point());
            end
            wait_drained();
        end
        stimulus_done = 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.command <= CMD_HEADER;
            in_ch.sync_point <= '0;
            in_ch.tick_ns <= '0;
            in_ch.start_line <= '0;
            in_ch.first_timestamp_ns <= '0;
            in_ch.peak_id <= '0;
            in_ch.point_flags <= '0;
            in_ch.range <= '0;
            in_ch.azimuth <= '0;
            in_ch.elevation <= '0;
            in_ch.velocity <= '0;
            in_ch.intensity <= '0;
            sent_count <= 0;
        end
        else
        begin
            lidar_item_t it;
            bit          offered;
            offered = in_ch.valid;
            if (in_ch.valid && in_ch.ready)
            begin
                decode_point({in_ch.command, in_ch.sync_point, in_ch.tick_ns,
                              in_ch.start_line, in_ch.first_timestamp_ns, in_ch.peak_id,
                              in_ch.point_flags, in_ch.range, in_ch.azimuth,
                              in_ch.elevation, in_ch.velocity, in_ch.intensity});
                sent_count <= sent_count + 1;
                offered = 0;
            end
            if (!offered)
            begin
                if (pending_items.size() != 0 && (no_idle || $urandom_range(0, 99) >= 23))
                begin
                    it = pending_items.pop_front();
                    in_ch.valid <= 1'b1;
                    {in_ch.command, in_ch.sync_point, in_ch.tick_ns,
                     in_ch.start_line, in_ch.first_timestamp_ns, in_ch.peak_id,
                     in_ch.point_flags, in_ch.range, in_ch.azimuth, in_ch.elevation,
                     in_ch.velocity, in_ch.intensity} <= it;
                end
                else
                    in_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            hold_off_left <= 0;
            hold_off_done <= 1'b0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                cart_point_t got, want;
                got = {out_ch.kind, out_ch.x, out_ch.y, out_ch.z, out_ch.distance,
                       out_ch.azimuth_rad, out_ch.elevation_rad, out_ch.echo_kind,
                       out_ch.radial_vel, out_ch.point_intensity, out_ch.time_ns,
                       out_ch.channel};
                if (expected_points.size() == 0)
                begin
                    $display("%0t: unexpected transaction, expected none, actual %p",
                             $time, got);
                    failed = 1;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: transaction differs, expected %p, actual %p",
                                 $time, want, got);
                        failed = 1;
                    end
                end
            end
            if (hold_off_req && !hold_off_done && sent_count > 400 && hold_off_left == 0)
            begin
                hold_off_done <= 1'b1;
                hold_off_left <= HOLD_OFF_CYCLES;
                out_ch.ready <= 1'b0;
            end
            else if (hold_off_left > 0)
            begin
                hold_off_left <= hold_off_left - 1;
                out_ch.ready <= (hold_off_left == 1);
            end
            else
                out_ch.ready <= no_idle || ($urandom_range(0, 99) >= 23);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
            || cfg.valid)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (stimulus_done || idle_cycles >= IDLE_LIMIT);
        if (stimulus_done)
        begin
            if (!failed && expected_points.size() == 0)
                $display("lidar_point_decode_cartesian: match");
            else
                $display("lidar_point_decode_cartesian: mismatch");
        end
        else
            $display("lidar_point_decode_cartesian: mismatch");
        $finish;
    end

endmodule
